FILE: rtl/des_ks_pkg.sv
// Package: DES key schedule tables, item types and bit-selection functions.
package des_ks_pkg;

    localparam int KEY_BITS   = 64;
    localparam int CD_BITS    = 56;
    localparam int HALF_BITS  = 28;
    localparam int SUB_BITS   = 48;
    localparam int ROUNDS     = 16;
    localparam int ROUND_W    = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;
    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd0;

    // Key permutation that drops the parity bits, 1-based positions, MSB first
    localparam logic [6:0] PC1_TAB [0:CD_BITS-1] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
        7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // Subkey selection, 1-based positions into C||D
    localparam logic [5:0] PC2_TAB [0:SUB_BITS-1] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Left rotation per round
    localparam logic [1:0] ROT_TAB [0:ROUNDS-1] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    // One round item between the round generator and PC-2
    typedef struct packed {
        logic [ROUND_W-1:0] rnd;
        logic               last;
        logic [CD_BITS-1:0] cd;
    } t_rnd_item;

    // Low 7 bits of each byte to the high bits, odd parity in bit 0
    function automatic logic [KEY_BITS-1:0] build_key(input logic [KEY_BITS-1:0] raw);
        logic [KEY_BITS-1:0] k;
        logic [6:0]          b;
        k = '0;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 7];
            k[8*i +: 8] = {b, ~(^b)};
        end
        return k;
    endfunction

    function automatic logic [CD_BITS-1:0] pc1(input logic [KEY_BITS-1:0] k);
        logic [CD_BITS-1:0] cd;
        cd = '0;
        for (int i = 0; i < CD_BITS; i++) begin
            cd[CD_BITS-1-i] = k[6'(KEY_BITS - int'(PC1_TAB[i]))];
        end
        return cd;
    endfunction

    function automatic logic [SUB_BITS-1:0] pc2(input logic [CD_BITS-1:0] cd);
        logic [SUB_BITS-1:0] sub;
        sub = '0;
        for (int j = 0; j < SUB_BITS; j++) begin
            sub[SUB_BITS-1-j] = cd[6'(CD_BITS - int'(PC2_TAB[j]))];
        end
        return sub;
    endfunction

    function automatic logic [HALF_BITS-1:0] rot28(input logic [HALF_BITS-1:0] h,
                                                   input logic [1:0] s);
        logic [HALF_BITS-1:0] r;
        if (s == 2'd2) begin
            r = {h[HALF_BITS-3:0], h[HALF_BITS-1:HALF_BITS-2]};
        end else begin
            r = {h[HALF_BITS-2:0], h[HALF_BITS-1]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/des_ks_pc1.sv
// Input stage: parity key build and PC-1 into a registered C/D pair.
module des_ks_pc1 import des_ks_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_take,
    output logic                o_vld,
    output logic [CD_BITS-1:0]  o_cd,
    input  logic                i_take
);

    logic               r_vld;
    logic [CD_BITS-1:0] r_cd;
    logic               n_vld;

    // stage can load when empty or emptying
    assign o_take = !r_vld || i_take;
    assign n_vld  = o_take ? i_vld : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_vld) begin
            r_cd <= pc1(build_key(i_key));
        end
    end

    assign o_vld = r_vld;
    assign o_cd  = r_cd;

endmodule

FILE: rtl/des_ks_round.sv
// Round generator: holds C/D and steps through the 16 rotations, one item per cycle unless PC-2 stalls.
module des_ks_round import des_ks_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [CD_BITS-1:0] i_cd,
    output logic               o_take,
    output logic               o_vld,
    output t_rnd_item          o_item,
    input  logic               i_take
);

    logic                 r_vld;
    logic [ROUND_W-1:0]   r_rnd;
    logic [HALF_BITS-1:0] r_c;
    logic [HALF_BITS-1:0] r_d;
    logic                 n_vld;
    logic                 w_move;
    logic                 w_done;
    logic                 w_load;
    logic [ROUND_W-1:0]   w_nrnd;

    assign w_move = r_vld && i_take;
    assign w_done = w_move && (r_rnd == LAST_ROUND);
    // free for a new key when empty or finishing the last round
    assign o_take = !r_vld || w_done;
    assign w_load = o_take && i_vld;
    assign w_nrnd = r_rnd + 1'b1;

    always_comb begin
        n_vld = r_vld;
        if (o_take) begin
            n_vld = i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // halves hold the rotation state of the current round
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rnd <= FIRST_ROUND;
            r_c   <= rot28(i_cd[CD_BITS-1:HALF_BITS], ROT_TAB[FIRST_ROUND]);
            r_d   <= rot28(i_cd[HALF_BITS-1:0], ROT_TAB[FIRST_ROUND]);
        end else if (w_move && !w_done) begin
            r_rnd <= w_nrnd;
            r_c   <= rot28(r_c, ROT_TAB[w_nrnd]);
            r_d   <= rot28(r_d, ROT_TAB[w_nrnd]);
        end
    end

    assign o_vld       = r_vld;
    assign o_item.rnd  = r_rnd;
    assign o_item.last = (r_rnd == LAST_ROUND);
    assign o_item.cd   = {r_c, r_d};

endmodule

FILE: rtl/des_ks_pc2.sv
// Output stage: PC-2 into the output register.
module des_ks_pc2 import des_ks_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_rnd_item           i_item,
    output logic                o_take,
    output logic                o_vld,
    output logic [ROUND_W-1:0]  o_rnd,
    output logic [SUB_BITS-1:0] o_sub,
    output logic                o_last,
    input  logic                i_stall
);

    logic                r_vld;
    logic [ROUND_W-1:0]  r_rnd;
    logic [SUB_BITS-1:0] r_sub;
    logic                r_last;
    logic                n_vld;

    assign o_take = !r_vld || !i_stall;
    assign n_vld  = o_take ? i_vld : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_vld) begin
            r_rnd  <= i_item.rnd;
            r_sub  <= pc2(i_item.cd);
            r_last <= i_item.last;
        end
    end

    assign o_vld  = r_vld;
    assign o_rnd  = r_rnd;
    assign o_sub  = r_sub;
    assign o_last = r_last;

endmodule

FILE: rtl/des_key_schedule.sv
// Top level: DES key schedule, one key in, sixteen round subkeys out.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  key in   | i_valid / o_stall   | i_key_bytes[63:0]
//  subkey   | o_valid / i_stall   | o_round_index[3:0], o_subkey[47:0],
//           |                     | o_last_subkey
//
// Three register stages: PC-1, round generator, PC-2 output register.
// Each key yields 16 items, one per cycle while i_stall is low. A key passes
// the PC-1, round generator and PC-2 registers before o_valid rises. The next
// key waits in the PC-1 stage and enters as the last round leaves. Reset
// clears valid bits only. While i_stall is high, empty stages still fill,
// then the stall backs up to o_stall; nothing is lost or repeated.
module des_key_schedule import des_ks_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [KEY_BITS-1:0] i_key_bytes,
    output logic                o_stall,
    output logic                o_valid,
    output logic [ROUND_W-1:0]  o_round_index,
    output logic [SUB_BITS-1:0] o_subkey,
    output logic                o_last_subkey,
    input  logic                i_stall
);

    logic               w_in_take;
    logic               w_a_vld;
    logic [CD_BITS-1:0] w_a_cd;
    logic               w_a_take;
    logic               w_b_vld;
    t_rnd_item          w_b_item;
    logic               w_b_take;

    assign o_stall = !w_in_take;

    // PC-1 stage
    des_ks_pc1 u_pc1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid),
        .i_key   (i_key_bytes),
        .o_take  (w_in_take),
        .o_vld   (w_a_vld),
        .o_cd    (w_a_cd),
        .i_take  (w_a_take)
    );

    // round generator
    des_ks_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_a_vld),
        .i_cd    (w_a_cd),
        .o_take  (w_a_take),
        .o_vld   (w_b_vld),
        .o_item  (w_b_item),
        .i_take  (w_b_take)
    );

    // PC-2 and output register
    des_ks_pc2 u_pc2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_b_vld),
        .i_item  (w_b_item),
        .o_take  (w_b_take),
        .o_vld   (o_valid),
        .o_rnd   (o_round_index),
        .o_sub   (o_subkey),
        .o_last  (o_last_subkey),
        .i_stall (i_stall)
    );

endmodule

FILE: tb/des_key_schedule_test.sv
// Testbench for des_key_schedule: directed and random keys against a round predictor.
module des_key_schedule_test;
    import des_ks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_KEYS = 250;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;

    // Bit selections, 1-based, bit 1 is the MSB
    localparam int KEY_PICK [0:CD_BITS-1] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };
    localparam int SUBKEY_PICK [0:SUB_BITS-1] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };
    localparam int ROT_AMT [0:ROUNDS-1] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    // Directed keys; fixed marks rows whose subkeys are all equal to sub
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                fixed;
        logic [SUB_BITS-1:0] sub;
    } t_key_row;

    localparam int N_DIRECTED = 20;
    localparam t_key_row DIRECTED_KEYS [0:N_DIRECTED-1] = '{
        '{64'h0000_0000_0000_0000, 1'b1, 48'h0000_0000_0000},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{64'h7F7F_7F7F_7F7F_7F7F, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{64'h8080_8080_8080_8080, 1'b1, 48'h0000_0000_0000},
        '{64'h0101_0101_0101_0101, 1'b0, 48'h0},
        '{64'h4040_4040_4040_4040, 1'b0, 48'h0},
        '{64'h5555_5555_5555_5555, 1'b0, 48'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 48'h0},
        '{64'h091A_2B3C_4D5E_6F78, 1'b0, 48'h0},
        '{64'h7F00_0000_0000_0000, 1'b0, 48'h0},
        '{64'h0000_0000_0000_007F, 1'b0, 48'h0},
        '{64'h0123_4567_89AB_CDEF, 1'b0, 48'h0},
        '{64'hFEDC_BA98_7654_3210, 1'b0, 48'h0},
        '{64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 48'h0},
        '{64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 48'h0},
        '{64'h0000_0001_0000_0000, 1'b0, 48'h0},
        '{64'h8000_0000_0000_0001, 1'b0, 48'h0},
        '{64'h7E7E_7E7E_7E7E_7E7E, 1'b0, 48'h0},
        '{64'h1F1F_1F1F_0E0E_0E0E, 1'b0, 48'h0},
        '{64'h3C3C_3C3C_C3C3_C3C3, 1'b0, 48'h0}
    };

    typedef struct packed {
        logic [ROUND_W-1:0]  rnd;
        logic [SUB_BITS-1:0] sub;
        logic                last;
    } t_subkey;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [KEY_BITS-1:0] i_key_bytes = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [ROUND_W-1:0]  o_round_index;
    logic [SUB_BITS-1:0] o_subkey;
    logic                o_last_subkey;

    t_subkey subkey_q [$];
    int      n_errors = 0;
    int      n_keys_sent = 0;
    int      n_subkeys_seen = 0;
    int      n_input_stalls = 0;
    int      n_holds = 0;
    int      hold_pending = 0;
    int      burst_left = 0;
    int      cycle_count = 0;

    des_key_schedule u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_key_bytes   (i_key_bytes),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_round_index (o_round_index),
        .o_subkey      (o_subkey),
        .o_last_subkey (o_last_subkey),
        .i_stall       (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // Expand one raw key into its sixteen round subkeys and queue them
    function automatic void queue_subkeys(input logic [KEY_BITS-1:0] raw, input logic fixed,
                                          input logic [SUB_BITS-1:0] fixed_sub);
        logic [KEY_BITS-1:0]  des_key;
        logic [CD_BITS-1:0]   cd;
        logic [HALF_BITS-1:0] c_half;
        logic [HALF_BITS-1:0] d_half;
        logic [6:0]           seven;
        t_subkey              item;
        for (int i = 0; i < 8; i++) begin
            seven = raw[8*i +: 7];
            des_key[8*i +: 8] = {seven, ~(^seven)};
        end
        for (int i = 0; i < CD_BITS; i++) begin
            cd[CD_BITS-1-i] = des_key[KEY_BITS - KEY_PICK[i]];
        end
        c_half = cd[CD_BITS-1:HALF_BITS];
        d_half = cd[HALF_BITS-1:0];
        for (int r = 0; r < ROUNDS; r++) begin
            if (ROT_AMT[r] == 2) begin
                c_half = {c_half[HALF_BITS-3:0], c_half[HALF_BITS-1:HALF_BITS-2]};
                d_half = {d_half[HALF_BITS-3:0], d_half[HALF_BITS-1:HALF_BITS-2]};
            end else begin
                c_half = {c_half[HALF_BITS-2:0], c_half[HALF_BITS-1]};
                d_half = {d_half[HALF_BITS-2:0], d_half[HALF_BITS-1]};
            end
            cd = {c_half, d_half};
            for (int j = 0; j < SUB_BITS; j++) begin
                item.sub[SUB_BITS-1-j] = cd[CD_BITS - SUBKEY_PICK[j]];
            end
            if (fixed) begin
                item.sub = fixed_sub;
            end
            item.rnd = ROUND_W'(r);
            item.last = (item.rnd == LAST_ROUND);
            subkey_q.push_back(item);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Offer one key, in bursts with random gaps between them
    task automatic offer_key(input logic [KEY_BITS-1:0] key, input logic fixed,
                             input logic [SUB_BITS-1:0] fixed_sub);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_key_bytes <= key;
        do begin
            @(posedge i_clk);
            if (o_stall) n_input_stalls++;
        end while (o_stall);
        queue_subkeys(key, fixed, fixed_sub);
        n_keys_sent++;
        if (n_keys_sent == 60 || n_keys_sent == 180) hold_pending++;
    endtask

    // Subkey checker
    always @(posedge i_clk) begin
        t_subkey want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_subkeys_seen++;
            if (subkey_q.size() == 0) begin
                report_mismatch("unexpected subkey", 64'(o_subkey), 64'd0);
            end else begin
                want = subkey_q.pop_front();
                if (o_round_index !== want.rnd)
                    report_mismatch("round_index", 64'(o_round_index), 64'(want.rnd));
                if (o_subkey !== want.sub)
                    report_mismatch("subkey", 64'(o_subkey), 64'(want.sub));
                if (o_last_subkey !== want.last)
                    report_mismatch("last_subkey", 64'(o_last_subkey), 64'(want.last));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d subkeys outstanding",
                     cycle_count, subkey_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall: changing patterns, plus long hold-offs on request
    initial begin
        int mode;
        int span;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending > 0) begin
                hold_pending--;
                n_holds++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Reset, stimulus and end of run
    initial begin
        logic [KEY_BITS-1:0] key;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            offer_key(DIRECTED_KEYS[n].key, DIRECTED_KEYS[n].fixed, DIRECTED_KEYS[n].sub);
        end

        for (int n = 0; n < RANDOM_KEYS; n++) begin
            key = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                6: key = 64'd1 << $urandom_range(0, KEY_BITS - 1);
                7: key = {8{key[7:0]}};
                8: key = key | 64'h8080_8080_8080_8080;
                9: key = key & 64'h7F7F_7F7F_7F7F_7F7F;
                default: ;
            endcase
            offer_key(key, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (subkey_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d keys (%0d directed, %0d random), checked %0d subkeys.",
                 n_keys_sent, N_DIRECTED, RANDOM_KEYS, n_subkeys_seen);
        $display("Output held off %0d times for %0d cycles; input stalled %0d cycles.",
                 n_holds, HOLD_CYCLES, n_input_stalls);
        if (n_errors == 0 && subkey_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
